FILE: src/baac_pkg.sv
// Shared types, constants and coefficient defaults for the block average
// converter calibration unit. No dependencies.
`default_nettype none

package baac_pkg;

    // Frames summed per block (1 to 256).
    localparam int BLOCK_SAMPLES = 16;

    localparam int NUM_CH     = 6;
    localparam int NUM_COEF   = 12;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_IDX_W = 4;
    localparam int COEF_W     = 32;
    localparam int VALUE_W    = 32;

    // Sum wide enough for BLOCK_SAMPLES full-scale words.
    localparam int SUM_W  = SAMPLE_W + $clog2(BLOCK_SAMPLES);
    localparam int FCNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

    // Stream packing
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = NUM_CH * VALUE_W;
    localparam int IDX_LSB   = NUM_CH * SAMPLE_W;
    localparam int CVAL_LSB  = IDX_LSB + COEF_IDX_W;

    // Converter scale 1/1241.58836 as an exact ratio
    localparam int CONV_NUM_W = 15;
    localparam logic [CONV_NUM_W-1:0] CONV_NUM = 15'd25000;
    localparam logic [COEF_W-1:0]     CONV_DEN = 32'd31039709;
    localparam int X_W = SAMPLE_W + CONV_NUM_W;   // avg * CONV_NUM
    localparam int V_W = 30;                      // converted value, UQ.24

    // Serial divider geometry
    localparam int DIV_NW = 56;
    localparam int DIV_VW = 32;
    localparam int DIV_CW = 6;
    localparam int CAL_QW = COEF_W + 16;          // (mag << 16) / k

    localparam logic [DIV_CW-1:0] NB_AVG  = DIV_CW'(SUM_W);
    localparam logic [DIV_CW-1:0] NB_CONV = DIV_CW'(X_W + 24);
    localparam logic [DIV_CW-1:0] NB_CAL  = DIV_CW'(CAL_QW);

    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

    // Coefficient defaults, UQ8.24
    localparam logic [COEF_W-1:0] K_VOLT_DEF = 32'd90732;
    localparam logic [COEF_W-1:0] K_CURR_DEF = 32'd1036072;
    localparam logic [COEF_W-1:0] Q_VOLT_DEF = 32'd1515016;
    localparam logic [COEF_W-1:0] Q_CURR_DEF = 32'd1068758;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_COEF   = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_MUL,
        ST_CONV_GO,
        ST_CONV_WAIT,
        ST_DIFF,
        ST_CAL_GO,
        ST_CAL_WAIT,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] nbits;
        logic [DIV_VW-1:0] divisor;
        logic [DIV_NW-1:0] dividend;   // left aligned
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    function automatic logic [COEF_W-1:0] coef_default(input logic [COEF_IDX_W-1:0] idx);
        logic [COEF_W-1:0] val;
        unique case (idx)
            4'd0, 4'd1, 4'd2:  val = K_VOLT_DEF;
            4'd3, 4'd4, 4'd5:  val = K_CURR_DEF;
            4'd6, 4'd7, 4'd8:  val = Q_VOLT_DEF;
            4'd9, 4'd10, 4'd11: val = Q_CURR_DEF;
            default:           val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: src/baac_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on baac_pkg (request and response structs, widths).
`default_nettype none

module baac_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire baac_pkg::div_req_t  req,
    output baac_pkg::div_rsp_t       rsp
);
    import baac_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_VW-1:0] rem_next;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_VW-1:0] dvs_reg;
    logic [DIV_VW:0]   shifted;
    logic [DIV_VW:0]   diff;
    logic              ge;

    // remainder stays below the divisor, so the shifted value fits DIV_VW+1 bits
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_NW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? diff[DIV_VW-1:0] : shifted[DIV_VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/block_average_adc_calibration.sv
// Block average converter front end: frame sums, averaging, linear calibration.
// A frame or coefficient beat is absorbed as it is accepted; the frame closing a block
// starts the per-channel calculation; a zero gain skips its calibration divide.
// Throughput: one beat per cycle outside that calculation and a wait for a free output
// register; the shared bit-serial divider sets the calculation time. Results wait there.
// Reset (aresetn, sync, active low): sums, frame count cleared, coefficients default.
`default_nettype none

module block_average_adc_calibration (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: sample_0..sample_5 [95:0], coef_index [99:96], coef_value [131:100]
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [baac_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [0:0]                        s_tuser,   // command
    // m_tdata: value_0..value_5, 32 bits each, value_0 lowest
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [baac_pkg::M_TDATA_W-1:0]    m_tdata,
    output      logic [0:0]                        m_tuser    // saturated
);
    import baac_pkg::*;

    state_t state_reg, state_next;

    // accumulation
    logic [SUM_W-1:0]  sum_reg [NUM_CH];
    logic [FCNT_W-1:0] frame_cnt_reg;
    logic              s_beat;
    logic              frame_beat;
    logic              last_frame;

    // coefficient table: memory plus per-entry valid bits (invalid reads default)
    logic [COEF_W-1:0]     coef_mem [NUM_COEF];
    logic [NUM_COEF-1:0]   coef_vld_reg;
    logic [COEF_W-1:0]     k_raw_reg, q_raw_reg;
    logic                  k_vld_reg, q_vld_reg;
    logic [COEF_W-1:0]     k_eff, q_eff;
    logic [COEF_IDX_W-1:0] k_addr, q_addr;
    logic [COEF_IDX_W-1:0] wr_idx;

    // per-channel datapath
    logic [CH_W-1:0]    ch_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [X_W-1:0]     x_reg;
    logic [V_W-1:0]     v_reg;
    logic               neg_reg;
    logic [COEF_W-1:0]  mag_reg;
    logic               neg_now;
    logic [CAL_QW-1:0]  quo;
    logic [VALUE_W-1:0] res_reg [NUM_CH];
    logic               sat_reg;
    logic               k_zero;
    logic               last_ch;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 out_free;
    logic                 out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    baac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_beat     = s_tvalid && s_tready;
    assign frame_beat = s_beat && (s_tuser[0] == CMD_SAMPLE);
    assign last_frame = frame_cnt_reg == FCNT_W'(BLOCK_SAMPLES - 1);
    assign wr_idx     = s_tdata[IDX_LSB +: COEF_IDX_W];

    assign k_addr = COEF_IDX_W'(ch_reg);
    assign q_addr = COEF_IDX_W'(ch_reg) + COEF_IDX_W'(NUM_CH);
    assign k_eff  = k_vld_reg ? k_raw_reg : coef_default(k_addr);
    assign q_eff  = q_vld_reg ? q_raw_reg : coef_default(q_addr);
    assign k_zero = k_eff == '0;
    assign last_ch = ch_reg == CH_W'(NUM_CH - 1);
    assign neg_now = {{(COEF_W-V_W){1'b0}}, v_reg} < q_eff;
    assign quo     = div_rsp.quotient[CAL_QW-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (frame_beat && last_frame) state_next = ST_AVG_GO;
            ST_AVG_GO:    state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (div_rsp.done) state_next = ST_MUL;
            ST_MUL:       state_next = ST_CONV_GO;
            ST_CONV_GO:   state_next = ST_CONV_WAIT;
            ST_CONV_WAIT: if (div_rsp.done) state_next = ST_DIFF;
            ST_DIFF:      state_next = k_zero ? ST_NEXT : ST_CAL_GO;
            ST_CAL_GO:    state_next = ST_CAL_WAIT;
            ST_CAL_WAIT:  if (div_rsp.done) state_next = ST_NEXT;
            ST_NEXT:      state_next = last_ch ? ST_OUT : ST_AVG_GO;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready         = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.nbits    = NB_AVG;
        div_req.divisor  = DIV_VW'(BLOCK_SAMPLES);
        div_req.dividend = {sum_reg[ch_reg], {(DIV_NW-SUM_W){1'b0}}};
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_AVG_GO:  div_req.start = 1'b1;
            ST_CONV_GO: begin
                div_req.start    = 1'b1;
                div_req.nbits    = NB_CONV;
                div_req.divisor  = CONV_DEN;
                div_req.dividend = {x_reg, {(DIV_NW-X_W){1'b0}}};
            end
            ST_CAL_GO: begin
                div_req.start    = 1'b1;
                div_req.nbits    = NB_CAL;
                div_req.divisor  = k_eff;
                div_req.dividend = {mag_reg, {(DIV_NW-COEF_W){1'b0}}};
            end
            ST_OUT:     out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // frame sums and block counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cnt_reg <= '0;
            for (int i = 0; i < NUM_CH; i++) sum_reg[i] <= '0;
        end else begin
            if (frame_beat) begin
                frame_cnt_reg <= last_frame ? '0 : frame_cnt_reg + FCNT_W'(1);
                for (int i = 0; i < NUM_CH; i++) begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(s_tdata[i*SAMPLE_W +: SAMPLE_W]);
                end
            end
            // the divider has captured this channel's sum
            if (state_reg == ST_AVG_GO) sum_reg[ch_reg] <= '0;
        end
    end

    // coefficient table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
        end else if (s_beat && (s_tuser[0] == CMD_COEF) && (wr_idx < COEF_IDX_W'(NUM_COEF))) begin
            coef_vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && (s_tuser[0] == CMD_COEF) && (wr_idx < COEF_IDX_W'(NUM_COEF))) begin
            coef_mem[wr_idx] <= s_tdata[CVAL_LSB +: COEF_W];
        end
        k_raw_reg <= coef_mem[k_addr];
        q_raw_reg <= coef_mem[q_addr];
        k_vld_reg <= coef_vld_reg[k_addr];
        q_vld_reg <= coef_vld_reg[q_addr];
    end

    // channel sequencing and saturation flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg  <= '0;
            sat_reg <= 1'b0;
        end else begin
            if (state_reg == ST_IDLE && frame_beat && last_frame) sat_reg <= 1'b0;
            if (state_reg == ST_NEXT) ch_reg <= last_ch ? '0 : ch_reg + CH_W'(1);
            if (state_reg == ST_DIFF && k_zero) sat_reg <= 1'b1;
            if (state_reg == ST_CAL_WAIT && div_rsp.done) begin
                if (neg_reg ? (quo > CAL_QW'(VAL_MIN)) : (quo > CAL_QW'(VAL_MAX))) begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    // per-channel arithmetic
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_AVG_WAIT:  if (div_rsp.done) avg_reg <= div_rsp.quotient[SAMPLE_W-1:0];
            ST_MUL:       x_reg <= X_W'(avg_reg) * X_W'(CONV_NUM);
            ST_CONV_WAIT: if (div_rsp.done) v_reg <= div_rsp.quotient[V_W-1:0];
            ST_DIFF: begin
                neg_reg <= neg_now;
                mag_reg <= neg_now ? q_eff - COEF_W'(v_reg) : COEF_W'(v_reg) - q_eff;
                // zero gain: full scale with the sign of the difference
                if (k_zero) res_reg[ch_reg] <= neg_now ? VAL_MIN : VAL_MAX;
            end
            ST_CAL_WAIT: begin
                if (div_rsp.done) begin
                    if (neg_reg) begin
                        res_reg[ch_reg] <= (quo > CAL_QW'(VAL_MIN)) ? VAL_MIN
                                         : VALUE_W'(0) - quo[VALUE_W-1:0];
                    end else begin
                        res_reg[ch_reg] <= (quo > CAL_QW'(VAL_MAX)) ? VAL_MAX
                                         : quo[VALUE_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // output register; frames keep flowing while a result waits here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < NUM_CH; i++) m_tdata_reg[i*VALUE_W +: VALUE_W] <= res_reg[i];
            m_tuser_reg <= sat_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // checks
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_AVG_WAIT || state_reg == ST_CONV_WAIT ||
                          state_reg == ST_CAL_WAIT))
        else $error("divider result arrived outside a wait state");

    a_frame_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_cnt_reg <= FCNT_W'(BLOCK_SAMPLES - 1))
        else $error("frame counter past block size");

    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && state_reg == ST_IDLE)
        else $error("result not presented after calculation");

endmodule

`default_nettype wire
